[src/msvc_pkg.sv]
// Package for the mixture state variable converter: sizes, field layout,
// fault and register codes, and the saturating Q32.32 helper functions.
// No dependencies.
`default_nettype none
package msvc_pkg;

  localparam int NUM_SPECIES = 4;
  localparam int NUM_DIMS    = 3;
  localparam int MAX_SPECIES = 4;
  localparam int MAX_DIMS    = 3;
  localparam int DIV_STAGES  = 128;

  localparam int DENS_W     = 63;
  localparam int Q_W        = 64;
  localparam int PROD_W     = 2 * Q_W;
  localparam int COMP_LSB   = DENS_W * MAX_SPECIES;
  localparam int ENERGY_LSB = COMP_LSB + Q_W * MAX_DIMS;
  localparam int TDATA_W    = ((ENERGY_LSB + Q_W + 7) / 8) * 8;
  localparam int CFG_IDX_W  = 3;
  localparam int SPC_IDX_W  = 2;

  typedef logic signed [Q_W-1:0] q_t;
  typedef logic [DENS_W-1:0]     u63_t;

  localparam q_t   Q_MAX   = {1'b0, {(Q_W-1){1'b1}}};
  localparam q_t   Q_MIN   = {1'b1, {(Q_W-1){1'b0}}};
  localparam u63_t RHO_MAX = {DENS_W{1'b1}};

  // Operation codes
  localparam logic OP_FWD = 1'b0;
  localparam logic OP_REV = 1'b1;

  // Fault codes
  localparam logic [1:0] FAULT_OK       = 2'd0;
  localparam logic [1:0] FAULT_NEG_T    = 2'd1;
  localparam logic [1:0] FAULT_ZERO_DIV = 2'd2;
  localparam logic [1:0] FAULT_SAT      = 2'd3;

  // Register index bases
  localparam logic [CFG_IDX_W-1:0] CFG_H0_BASE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CV_BASE = 3'd4;

  typedef struct packed {
    logic sat;
    q_t   v;
  } sq_t;

  // Sideband that travels alongside the divider pipelines
  typedef struct packed {
    logic                          op;
    logic [MAX_SPECIES-1:0][62:0]  rho;
    q_t                            last;
    u63_t                          rho_mix;
    q_t                            e_h0;
    q_t                            cv_mix;
    logic                          sat_c;
    logic                          sat_f;
    logic                          sat_r;
    logic [MAX_DIMS-1:0]           comp_neg;
    logic [MAX_DIMS-1:0][Q_W-1:0]  res;
    q_t                            total;
    q_t                            aux;
    logic                          num_neg;
  } side_t;

  function automatic sq_t sat_add(input q_t a, input q_t b);
    logic signed [Q_W:0] s;
    sq_t r;
    s = {a[Q_W-1], a} + {b[Q_W-1], b};
    r.sat = s[Q_W] ^ s[Q_W-1];
    if (!r.sat) r.v = s[Q_W-1:0];
    else if (s[Q_W]) r.v = Q_MIN;
    else r.v = Q_MAX;
    return r;
  endfunction

  function automatic sq_t sat_sub(input q_t a, input q_t b);
    logic signed [Q_W:0] s;
    sq_t r;
    s = {a[Q_W-1], a} - {b[Q_W-1], b};
    r.sat = s[Q_W] ^ s[Q_W-1];
    if (!r.sat) r.v = s[Q_W-1:0];
    else if (s[Q_W]) r.v = Q_MIN;
    else r.v = Q_MAX;
    return r;
  endfunction

  // Apply a sign to a magnitude, saturating to the signed range
  function automatic sq_t sat_mag(input logic neg, input logic up_nz, input logic [Q_W-1:0] q);
    sq_t r;
    if (!neg) begin
      r.sat = up_nz | q[Q_W-1];
      r.v   = r.sat ? Q_MAX : q_t'(q);
    end else begin
      r.sat = up_nz | (q[Q_W-1] & (|q[Q_W-2:0]));
      r.v   = (up_nz | q[Q_W-1]) ? Q_MIN : q_t'(-q);
    end
    return r;
  endfunction

  // Scale a magnitude product by 2^-32, floor on the signed value, saturate
  function automatic sq_t qscale(input logic neg, input logic [PROD_W-1:0] p);
    logic [Q_W:0] qq;
    logic         upz;
    qq  = {1'b0, p[95:32]} + (Q_W+1)'(neg && (p[31:0] != '0));
    upz = (p[PROD_W-1:96] != '0) | qq[Q_W];
    return sat_mag(neg, upz, qq[Q_W-1:0]);
  endfunction

  function automatic logic [Q_W-1:0] mag(input q_t a);
    return a[Q_W-1] ? Q_W'(-a) : Q_W'(a);
  endfunction

endpackage
`default_nettype wire

[src/msvc_mul.sv]
// Two-stage signed Q32.32 multiplier: 32x32 partial products, then sum,
// round and saturate. Depends on msvc_pkg.
`default_nettype none
module msvc_mul import msvc_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  q_t                a,
  input  q_t                b,
  output logic [PROD_W-1:0] prod,
  output sq_t               res
);

  logic [Q_W-1:0]    ma, mb;
  logic [63:0]       p00_r, p01_r, p10_r, p11_r;
  logic              neg_r;
  logic [PROD_W-1:0] full;
  logic [PROD_W-1:0] prod_r;
  sq_t               res_r;

  assign ma = mag(a);
  assign mb = mag(b);

  // Partial products of the magnitudes
  always_ff @(posedge clk) begin
    if (en) begin
      p00_r <= ma[31:0]  * mb[31:0];
      p01_r <= ma[31:0]  * mb[63:32];
      p10_r <= ma[63:32] * mb[31:0];
      p11_r <= ma[63:32] * mb[63:32];
      neg_r <= a[Q_W-1] ^ b[Q_W-1];
    end
  end

  assign full = {p11_r, 64'b0} + {32'b0, p01_r, 32'b0} + {32'b0, p10_r, 32'b0}
              + {64'b0, p00_r};

  // Sum, scale and saturate
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= full;
      res_r  <= qscale(neg_r, full);
    end
  end

  assign prod = prod_r;
  assign res  = res_r;

endmodule
`default_nettype wire

[src/msvc_div.sv]
// Restoring divider, one quotient bit per stage: 128-bit dividend by a
// 63-bit divisor. Depends on msvc_pkg.
`default_nettype none
module msvc_div import msvc_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [PROD_W-1:0] num,
  input  u63_t              den,
  output logic [PROD_W-1:0] quo
);

  logic [63:0]       rem_r   [DIV_STAGES];
  logic [PROD_W-1:0] wrk_r   [DIV_STAGES];
  u63_t              den_r   [DIV_STAGES];
  logic [63:0]       rem_in  [DIV_STAGES];
  logic [PROD_W-1:0] wrk_in  [DIV_STAGES];
  u63_t              den_in  [DIV_STAGES];
  logic [63:0]       rem_nxt [DIV_STAGES];
  logic [PROD_W-1:0] wrk_nxt [DIV_STAGES];

  // Chain stage inputs
  always_comb begin
    rem_in[0] = '0;
    wrk_in[0] = num;
    den_in[0] = den;
    for (int i = 1; i < DIV_STAGES; i++) begin
      rem_in[i] = rem_r[i-1];
      wrk_in[i] = wrk_r[i-1];
      den_in[i] = den_r[i-1];
    end
  end

  // One shift, compare and subtract per stage
  always_comb begin
    logic [63:0] trial;
    logic        ge;
    for (int i = 0; i < DIV_STAGES; i++) begin
      trial      = {rem_in[i][62:0], wrk_in[i][PROD_W-1]};
      ge         = trial >= {1'b0, den_in[i]};
      rem_nxt[i] = ge ? trial - {1'b0, den_in[i]} : trial;
      wrk_nxt[i] = {wrk_in[i][PROD_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < DIV_STAGES; i++) begin
        rem_r[i] <= rem_nxt[i];
        wrk_r[i] <= wrk_nxt[i];
        den_r[i] <= den_in[i];
      end
    end
  end

  assign quo = wrk_r[DIV_STAGES-1];

endmodule
`default_nettype wire

[src/msvc_dly.sv]
// Sideband delay line matched to the divider depth, with valid bits.
// Depends on msvc_pkg.
`default_nettype none
module msvc_dly import msvc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  vld_in,
  input  side_t d,
  output logic  vld_out,
  output side_t q
);

  side_t                 sh_r [DIV_STAGES];
  logic [DIV_STAGES-1:0] vs_r;

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vs_r <= '0;
    end else if (en) begin
      vs_r <= {vs_r[DIV_STAGES-2:0], vld_in};
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      sh_r[0] <= d;
      for (int i = 1; i < DIV_STAGES; i++) sh_r[i] <= sh_r[i-1];
    end
  end

  assign vld_out = vs_r[DIV_STAGES-1];
  assign q       = sh_r[DIV_STAGES-1];

endmodule
`default_nettype wire

[src/mixture_state_variable_convert.sv]
// Top level of the mixture state variable converter: input stage, product
// stages, two divider passes and the output register. Depends on msvc_pkg,
// msvc_mul, msvc_div and msvc_dly.
//
//   channel | direction | payload
//   in_     | request   | tdata: density_0..3, comp_x/y/z, energy_or_temp; tuser: op
//   out_    | result    | tdata: density_0..3, comp_x/y/z, energy_or_temp; tuser: fault
//   cfg_    | write     | index 0..3 formation enthalpy, 4..7 heat capacity
//
// One request enters per cycle while the output is not stalled; each result passes
// through the product stages and then the two 128-stage bit-per-stage divider passes
// in series (velocity and kinetic term, then temperature).
// Reset (rst_n low, synchronous) empties the pipeline and clears the configuration registers.
// A stalled output holds the whole pipeline in place; nothing is dropped.
`default_nettype none
module mixture_state_variable_convert import msvc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [TDATA_W-1:0]   in_tdata,   // density_0..3, comp_x, comp_y, comp_z, energy_or_temp
  input  logic [0:0]           in_tuser,   // op
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [TDATA_W-1:0]   out_tdata,  // density_0..3, comp_x, comp_y, comp_z, energy_or_temp
  output logic [1:0]           out_tuser,  // fault
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [Q_W-1:0]       cfg_wdata
);

  typedef struct packed {
    logic                            op;
    logic [MAX_SPECIES-1:0][62:0]    rho;
    logic [MAX_DIMS-1:0][Q_W-1:0]    comp;
    q_t                              last;
    u63_t                            rho_mix;
    logic                            sat_c;
    logic                            sat_f;
    logic                            sat_r;
    q_t                              e_h0;
    q_t                              cv_mix;
    logic [MAX_DIMS-1:0][PROD_W-1:0] mm;
    q_t                              ek;
    q_t                              e_int;
    logic [MAX_DIMS-1:0][Q_W-1:0]    mom;
  } pipe_t;

  q_t    h0_r [MAX_SPECIES];
  u63_t  cv_r [MAX_SPECIES];
  pipe_t st_r [6];
  logic [5:0] v_r;
  pipe_t s0_nxt, s1_nxt, s3_nxt, s5_nxt;
  logic  adv;

  sq_t               hq_res  [MAX_SPECIES];
  sq_t               cvt_res [MAX_SPECIES];
  sq_t               rcv_res [MAX_SPECIES];
  sq_t               ei_res  [MAX_SPECIES];
  sq_t               vv_res  [MAX_DIMS];
  logic [PROD_W-1:0] vv_prod [MAX_DIMS];
  sq_t               mom_res [MAX_DIMS];
  sq_t               ekf_res [MAX_DIMS];
  logic [PROD_W-1:0] quo_v   [MAX_DIMS];
  logic [PROD_W-1:0] quo_k   [MAX_DIMS];
  logic [PROD_W-1:0] quo_t;
  logic [PROD_W-1:0] tnum;

  side_t side_in, side1, sp1_r, p1_nxt, p2_nxt, side2;
  logic  v1d, vp1_r, v2d, vf_r;
  logic [TDATA_W-1:0] out_tdata_r, fo_nxt;
  logic [1:0]         out_tuser_r, fault_nxt;

  assign adv       = !vf_r || out_tready;
  assign in_tready = adv;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < MAX_SPECIES; s++) begin
        h0_r[s] <= '0;
        cv_r[s] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index < CFG_CV_BASE) h0_r[cfg_index[SPC_IDX_W-1:0]] <= cfg_wdata;
      else cv_r[cfg_index[SPC_IDX_W-1:0]] <= cfg_wdata[DENS_W-1:0];
    end
  end

  // Unpack the request, zero unused slots
  always_comb begin
    s0_nxt    = '0;
    s0_nxt.op = in_tuser[0];
    for (int s = 0; s < MAX_SPECIES; s++)
      if (s < NUM_SPECIES) s0_nxt.rho[s] = in_tdata[DENS_W*s +: DENS_W];
    for (int k = 0; k < MAX_DIMS; k++)
      if (k < NUM_DIMS) s0_nxt.comp[k] = in_tdata[COMP_LSB + Q_W*k +: Q_W];
    s0_nxt.last = in_tdata[ENERGY_LSB +: Q_W];
  end

  // Mixture density
  always_comb begin
    logic [DENS_W+1:0] tot;
    s1_nxt = st_r[0];
    tot = '0;
    for (int s = 0; s < MAX_SPECIES; s++) tot = tot + (DENS_W+2)'(st_r[0].rho[s]);
    s1_nxt.sat_c   = tot > (DENS_W+2)'(RHO_MAX);
    s1_nxt.rho_mix = s1_nxt.sat_c ? RHO_MAX : tot[DENS_W-1:0];
  end

  // First products, issued from the input stage
  for (genvar s = 0; s < MAX_SPECIES; s++) begin : g_spc1
    msvc_mul u_hq (.clk, .en(adv), .a(q_t'({1'b0, st_r[0].rho[s]})), .b(h0_r[s]),
                   .prod(), .res(hq_res[s]));
    msvc_mul u_cvt (.clk, .en(adv), .a(q_t'({1'b0, cv_r[s]})), .b(st_r[0].last),
                    .prod(), .res(cvt_res[s]));
    msvc_mul u_rcv (.clk, .en(adv), .a(q_t'({1'b0, st_r[0].rho[s]})),
                    .b(q_t'({1'b0, cv_r[s]})), .prod(), .res(rcv_res[s]));
  end
  for (genvar k = 0; k < MAX_DIMS; k++) begin : g_dim1
    msvc_mul u_vv (.clk, .en(adv), .a(q_t'(st_r[0].comp[k])), .b(q_t'(st_r[0].comp[k])),
                   .prod(vv_prod[k]), .res(vv_res[k]));
  end

  // Second products, issued from stage 2
  for (genvar s = 0; s < MAX_SPECIES; s++) begin : g_spc2
    msvc_mul u_ei (.clk, .en(adv), .a(q_t'({1'b0, st_r[2].rho[s]})), .b(cvt_res[s].v),
                   .prod(), .res(ei_res[s]));
  end
  for (genvar k = 0; k < MAX_DIMS; k++) begin : g_dim2
    msvc_mul u_mom (.clk, .en(adv), .a(q_t'(st_r[2].comp[k])),
                    .b(q_t'({1'b0, st_r[2].rho_mix})), .prod(), .res(mom_res[k]));
    msvc_mul u_ekf (.clk, .en(adv), .a(q_t'({1'b0, st_r[2].rho_mix})), .b(vv_res[k].v),
                    .prod(), .res(ekf_res[k]));
  end

  // Formation enthalpy and mixture Cv sums
  always_comb begin
    sq_t t;
    q_t  eh, cm;
    s3_nxt = st_r[2];
    eh = '0;
    cm = '0;
    for (int s = 0; s < MAX_SPECIES; s++) begin
      t  = sat_add(eh, hq_res[s].v);
      s3_nxt.sat_c = s3_nxt.sat_c | hq_res[s].sat | t.sat;
      eh = t.v;
      t  = sat_add(cm, rcv_res[s].v);
      s3_nxt.sat_r = s3_nxt.sat_r | rcv_res[s].sat | t.sat;
      cm = t.v;
      s3_nxt.sat_f = s3_nxt.sat_f | cvt_res[s].sat;
    end
    for (int k = 0; k < MAX_DIMS; k++) begin
      s3_nxt.sat_f = s3_nxt.sat_f | vv_res[k].sat;
      s3_nxt.mm[k] = vv_prod[k];
    end
    s3_nxt.e_h0   = eh;
    s3_nxt.cv_mix = cm;
  end

  // Forward kinetic and internal energy sums
  always_comb begin
    sq_t t;
    q_t  ek, ei;
    s5_nxt = st_r[4];
    ek = '0;
    ei = '0;
    for (int k = 0; k < MAX_DIMS; k++) begin
      t  = sat_add(ek, ekf_res[k].v);
      s5_nxt.sat_f  = s5_nxt.sat_f | ekf_res[k].sat | mom_res[k].sat | t.sat;
      ek = t.v;
      s5_nxt.mom[k] = mom_res[k].v;
    end
    for (int s = 0; s < MAX_SPECIES; s++) begin
      t  = sat_add(ei, ei_res[s].v);
      s5_nxt.sat_f = s5_nxt.sat_f | ei_res[s].sat | t.sat;
      ei = t.v;
    end
    s5_nxt.ek    = ek >>> 1;
    s5_nxt.e_int = ei;
  end

  // Advance the product stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[4:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r[0] <= s0_nxt;
      st_r[1] <= s1_nxt;
      st_r[2] <= st_r[1];
      st_r[3] <= s3_nxt;
      st_r[4] <= st_r[3];
      st_r[5] <= s5_nxt;
    end
  end

  // Forward total energy and sideband for the first divider pass
  always_comb begin
    sq_t t, t2;
    t  = sat_add(st_r[5].e_int, st_r[5].ek);
    t2 = sat_add(t.v, st_r[5].e_h0);
    side_in.op      = st_r[5].op;
    side_in.rho     = st_r[5].rho;
    side_in.last    = st_r[5].last;
    side_in.rho_mix = st_r[5].rho_mix;
    side_in.e_h0    = st_r[5].e_h0;
    side_in.cv_mix  = st_r[5].cv_mix;
    side_in.sat_c   = st_r[5].sat_c;
    side_in.sat_f   = st_r[5].sat_f | t.sat | t2.sat;
    side_in.sat_r   = st_r[5].sat_r;
    for (int k = 0; k < MAX_DIMS; k++) side_in.comp_neg[k] = st_r[5].comp[k][Q_W-1];
    side_in.res     = st_r[5].mom;
    side_in.total   = t2.v;
    side_in.aux     = '0;
    side_in.num_neg = 1'b0;
  end

  // Velocity and kinetic term quotients
  for (genvar k = 0; k < MAX_DIMS; k++) begin : g_div1
    msvc_div u_vel (.clk, .en(adv),
                    .num({32'b0, mag(q_t'(st_r[5].comp[k])), 32'b0}),
                    .den(st_r[5].rho_mix), .quo(quo_v[k]));
    msvc_div u_ke (.clk, .en(adv), .num(st_r[5].mm[k]), .den(st_r[5].rho_mix),
                   .quo(quo_k[k]));
  end

  msvc_dly u_dly1 (.clk, .rst_n, .en(adv), .vld_in(v_r[5]), .d(side_in),
                   .vld_out(v1d), .q(side1));

  // Reverse velocities and kinetic energy
  always_comb begin
    sq_t vel, ke, t;
    q_t  ek;
    p1_nxt = side1;
    ek = '0;
    for (int k = 0; k < MAX_DIMS; k++) begin
      vel = sat_mag(side1.comp_neg[k], |quo_v[k][PROD_W-1:Q_W], quo_v[k][Q_W-1:0]);
      ke  = sat_mag(1'b0, |quo_k[k][PROD_W-1:Q_W], quo_k[k][Q_W-1:0]);
      t   = sat_add(ek, ke.v);
      p1_nxt.sat_r = p1_nxt.sat_r | vel.sat | ke.sat | t.sat;
      ek  = t.v;
      if (side1.op == OP_REV) p1_nxt.res[k] = vel.v;
    end
    p1_nxt.aux = ek >>> 1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp1_r <= 1'b0;
    end else if (adv) begin
      vp1_r <= v1d;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) sp1_r <= p1_nxt;
  end

  // Temperature numerator
  always_comb begin
    sq_t t, t2;
    t  = sat_sub(sp1_r.last, sp1_r.aux);
    t2 = sat_sub(t.v, sp1_r.e_h0);
    p2_nxt = sp1_r;
    p2_nxt.sat_r   = sp1_r.sat_r | t.sat | t2.sat;
    p2_nxt.num_neg = t2.v[Q_W-1];
    tnum = {32'b0, mag(t2.v), 32'b0};
  end

  msvc_div u_temp (.clk, .en(adv), .num(tnum), .den(sp1_r.cv_mix[DENS_W-1:0]),
                   .quo(quo_t));

  msvc_dly u_dly2 (.clk, .rst_n, .en(adv), .vld_in(vp1_r), .d(p2_nxt),
                   .vld_out(v2d), .q(side2));

  // Select results and fault, pack the output
  always_comb begin
    sq_t  tres;
    logic rev, rmz, zd, neg_t, sat;
    tres  = sat_mag(side2.num_neg, |quo_t[PROD_W-1:Q_W], quo_t[Q_W-1:0]);
    rev   = side2.op == OP_REV;
    rmz   = side2.rho_mix == '0;
    zd    = rev && (rmz || side2.cv_mix == '0);
    neg_t = rev && !zd && tres.v[Q_W-1];
    sat   = side2.sat_c | (rev ? (side2.sat_r | tres.sat) : side2.sat_f);
    fo_nxt = '0;
    for (int s = 0; s < MAX_SPECIES; s++) fo_nxt[DENS_W*s +: DENS_W] = side2.rho[s];
    for (int k = 0; k < MAX_DIMS; k++)
      fo_nxt[COMP_LSB + Q_W*k +: Q_W] = (rev && rmz) ? '0 : side2.res[k];
    fo_nxt[ENERGY_LSB +: Q_W] = rev ? (zd ? '0 : tres.v) : side2.total;
    if (zd) fault_nxt = FAULT_ZERO_DIV;
    else if (neg_t) fault_nxt = FAULT_NEG_T;
    else if (sat) fault_nxt = FAULT_SAT;
    else fault_nxt = FAULT_OK;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= 1'b0;
    end else if (adv) begin
      vf_r <= v2d;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_tdata_r <= fo_nxt;
      out_tuser_r <= fault_nxt;
    end
  end

  assign out_tvalid = vf_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule
`default_nettype wire
